// ----- hdl/mux_adc_scan_average_smooth_defines.svh -----
// Assertion macros shared by the scanner RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef MUX_ADC_SCAN_AVERAGE_SMOOTH_DEFINES_SVH
`define MUX_ADC_SCAN_AVERAGE_SMOOTH_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define MAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define MAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MAS_ASSERT(lbl, prop, msg)
`define MAS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/mas_pkg.sv -----
// Types and constants of the multiplexed ADC scanner.
// No dependencies; used by every module of the block.
package mas_pkg;

  localparam int AVG_LOG2     = 3;
  localparam int AVG_COUNT    = 1 << AVG_LOG2;
  localparam int NUM_CHANNELS = 8;

  localparam int CHAN_FW = 3;   // width of the channel fields
  localparam int CH_AW   = $clog2(NUM_CHANNELS);
  localparam int SMP_W   = 12;
  localparam int EL_W    = 16;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 18;
  localparam int FILT_W  = 20;   // 12.8 fixed point
  localparam int FRAC_W  = 8;
  localparam int ALPHA_W = 9;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
  localparam logic [EL_W-1:0]    EL_MAX    = {EL_W{1'b1}};
  localparam logic [EL_W-1:0]    PERIOD_RST = EL_W'(10);
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = ALPHA_W'(205);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_SCAN_PERIOD = 2'd0,
    REG_ALPHA       = 2'd1,
    REG_EN_LOW      = 2'd2
  } cfg_reg_t;

  // Completed average handed from the scan control to the channel store.
  typedef struct packed {
    logic               done;
    logic [CHAN_FW-1:0] channel;
    logic [SMP_W-1:0]   mean;
  } scan_evt_t;

endpackage

// ----- hdl/mas_scan_ctrl.sv -----
// Scan timing and sample accumulation of the ADC scanner.
// Depends on mas_pkg and the assertion macro header.
`include "mux_adc_scan_average_smooth_defines.svh"

module mas_scan_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  mas_pkg::op_t                 op,
  input  logic [mas_pkg::SMP_W-1:0]    sample,
  input  logic [mas_pkg::EL_W-1:0]     scan_period,
  output mas_pkg::scan_evt_t           evt,
  output logic [mas_pkg::CHAN_FW-1:0]  scan_ch_nxt
);
  import mas_pkg::*;

  logic [EL_W-1:0]    elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [SUM_W-1:0]   sum_r, sum_nxt, sum_inc;
  logic [CHAN_FW-1:0] scan_ch_r, ch_adv;
  logic               due;

  localparam logic [CHAN_FW-1:0] LAST_CH = CHAN_FW'(NUM_CHANNELS - 1);

  assign due     = elapsed_r >= scan_period;
  assign sum_inc = sum_r + SUM_W'(sample);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign ch_adv  = (scan_ch_r == LAST_CH) ? '0 : scan_ch_r + CHAN_FW'(1);

  always_comb begin
    elapsed_nxt = elapsed_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    scan_ch_nxt = scan_ch_r;
    evt.done    = 1'b0;
    evt.channel = scan_ch_r;
    evt.mean    = SMP_W'(sum_inc >> AVG_LOG2);
    if (go) begin
      case (op)
        OP_TICK: begin
          if (elapsed_r != EL_MAX) elapsed_nxt = elapsed_r + EL_W'(1);
        end
        OP_SAMPLE: begin
          if (due) begin
            if (cnt_inc >= CNT_W'(AVG_COUNT)) begin
              evt.done    = 1'b1;
              elapsed_nxt = '0;
              cnt_nxt     = '0;
              sum_nxt     = '0;
              scan_ch_nxt = ch_adv;
            end else begin
              cnt_nxt = cnt_inc;
              sum_nxt = sum_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      scan_ch_r <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      scan_ch_r <= scan_ch_nxt;
    end
  end

  `MAS_ASSERT(a_cnt_bound, cnt_r < CNT_W'(AVG_COUNT), "sample count passed the average length")
  `MAS_ASSERT(a_done_clears, evt.done |=> (elapsed_r == '0 && cnt_r == '0 && sum_r == '0),
              "completed average did not clear the scan state")
  `MAS_ASSERT(a_idle_sample, (go && op == OP_SAMPLE && !due) |=> $stable(sum_r) && $stable(cnt_r),
              "sample taken while no scan was due")

endmodule

// ----- hdl/mas_chan_store.sv -----
// Per-channel raw and filtered values with the one-pole smoothing update.
// Depends on mas_pkg and the assertion macro header.
`include "mux_adc_scan_average_smooth_defines.svh"

module mas_chan_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mas_pkg::scan_evt_t            evt,
  input  logic                          rd_sel,
  input  logic [mas_pkg::CHAN_FW-1:0]   rd_ch,
  input  logic [mas_pkg::ALPHA_W-1:0]   alpha,
  output logic [mas_pkg::SMP_W-1:0]     new_filt,
  output logic [mas_pkg::SMP_W-1:0]     rd_raw,
  output logic [mas_pkg::SMP_W-1:0]     rd_filt
);
  import mas_pkg::*;

  logic [SMP_W-1:0]        raw_r  [NUM_CHANNELS];
  logic [FILT_W-1:0]       filt_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] primed_r;

  logic [CHAN_FW-1:0]      addr;
  logic [CH_AW-1:0]        idx;
  logic                    hit, in_range;
  logic [SMP_W-1:0]        raw_q;
  logic [FILT_W-1:0]       filt_q, filt_upd, mean_fx;
  logic [ALPHA_W-1:0]      a_sat;
  logic signed [FILT_W:0]  diff;
  logic signed [FILT_W+ALPHA_W+1:0] prod, acc;

  // One read port, shared: an update reads the scan channel, a read its own.
  assign addr     = rd_sel ? rd_ch : evt.channel;
  assign idx      = addr[CH_AW-1:0];
  assign in_range = {1'b0, addr} < (CHAN_FW + 1)'(NUM_CHANNELS);
  assign hit      = in_range && primed_r[idx];
  assign raw_q    = hit ? raw_r[idx]  : '0;
  assign filt_q   = hit ? filt_r[idx] : '0;

  // new = old + a * (mean * 256 - old) / 256, one multiplier.
  assign a_sat    = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign mean_fx  = {evt.mean, {FRAC_W{1'b0}}};
  assign diff     = $signed({1'b0, mean_fx}) - $signed({1'b0, filt_q});
  assign prod     = $signed({1'b0, a_sat}) * diff;
  assign acc      = $signed({{(ALPHA_W + 2 - FRAC_W){1'b0}}, filt_q, {FRAC_W{1'b0}}}) + prod;
  assign filt_upd = hit ? acc[FILT_W+FRAC_W-1:FRAC_W] : mean_fx;

  assign new_filt = filt_upd[FILT_W-1:FRAC_W];
  assign rd_raw   = raw_q;
  assign rd_filt  = filt_q[FILT_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (evt.done) begin
      raw_r[idx]  <= evt.mean;
      filt_r[idx] <= filt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= '0;
    end else if (evt.done) begin
      primed_r[idx] <= 1'b1;
    end
  end

  `MAS_ASSERT_ALWAYS(a_reset_unprimed, !rst_n |=> primed_r == '0, "reset left a channel primed")
  `MAS_ASSERT(a_update_primes, evt.done |=> primed_r[$past(idx)], "update did not prime channel")
  `MAS_ASSERT(a_primed_sticky, rst_n |=> (primed_r & $past(primed_r)) == $past(primed_r),
              "a primed channel lost its flag")

endmodule

// ----- hdl/mux_adc_scan_average_smooth.sv -----
// Top level of the multiplexed ADC scanner with per-channel smoothing.
// Depends on mas_pkg, mas_scan_ctrl and mas_chan_store.
//
// Usage: every request on the in_ channel is one of a millisecond tick, an
// ADC sample or a read of one channel, and each request yields exactly one
// result on the out_ channel, in order. Both channels use valid and ready.
// A request is captured in an input register; once the output register is
// free, the scan control and the channel store work on it in one pass of
// logic and the result lands in the output register. The block takes one
// request per cycle while the receiver keeps up: in_ready stays high
// whenever the output register is empty or is being emptied, so a result
// waiting for its receiver does not stop the next request from being
// captured. When the receiver stalls, the result holds, the one request
// behind it holds in the input register and in_ready drops.
// The smoothing update is one 10 x 21 bit multiply-add on the selected
// channel, which sets the length of the one combinational path.
// Synchronous reset clears the scan timer, accumulator, channel select and
// primed flags (unprimed channels read as zero), empties both registers and
// loads the configuration defaults. Configuration writes on cfg_ take effect
// at once; the user makes them only while the block is idle (unenforced).
module mux_adc_scan_average_smooth (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mas_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [mas_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [mas_pkg::SMP_W-1:0]     in_sample,
  input  logic [mas_pkg::CHAN_FW-1:0]   in_read_channel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mas_pkg::CHAN_FW-1:0]   out_mux_select,
  output logic                          out_mux_enable_level,
  output logic                          out_updated,
  output logic [mas_pkg::CHAN_FW-1:0]   out_updated_channel,
  output logic [mas_pkg::SMP_W-1:0]     out_new_raw,
  output logic [mas_pkg::SMP_W-1:0]     out_new_filtered,
  output logic [mas_pkg::SMP_W-1:0]     out_read_raw,
  output logic [mas_pkg::SMP_W-1:0]     out_read_filtered
);
  import mas_pkg::*;

  // Configuration registers.
  logic [EL_W-1:0]    period_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic               en_low_r;

  // Input register.
  logic               in_vld_r;
  logic [1:0]         op_r;
  logic [SMP_W-1:0]   sample_r;
  logic [CHAN_FW-1:0] rch_r;

  // Output register.
  logic               out_vld_r;
  logic [CHAN_FW-1:0] sel_r, upd_ch_r;
  logic               en_lvl_r, upd_r;
  logic [SMP_W-1:0]   new_raw_r, new_filt_r, rd_raw_r, rd_filt_r;

  logic               go, in_take, is_read;
  op_t                op;
  scan_evt_t          evt;
  logic [CHAN_FW-1:0] scan_ch_nxt;
  logic [SMP_W-1:0]   new_filt, rd_raw, rd_filt;

  // The captured request moves on whenever the output register is free.
  assign go       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || go;
  assign in_take  = in_valid && in_ready;
  assign op       = op_t'(op_r);
  assign is_read  = (op == OP_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      alpha_r  <= ALPHA_RST;
      en_low_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SCAN_PERIOD: period_r <= cfg_wdata[EL_W-1:0];
        REG_ALPHA:       alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        REG_EN_LOW:      en_low_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  mas_scan_ctrl u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .op          (op),
    .sample      (sample_r),
    .scan_period (period_r),
    .evt         (evt),
    .scan_ch_nxt (scan_ch_nxt)
  );

  mas_chan_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt      (evt),
    .rd_sel   (is_read),
    .rd_ch    (rch_r),
    .alpha    (alpha_r),
    .new_filt (new_filt),
    .rd_raw   (rd_raw),
    .rd_filt  (rd_filt)
  );

  // Control flops of the two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (go) begin
        in_vld_r <= 1'b0;
      end
      if (go) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload flops; no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_op;
      sample_r <= in_sample;
      rch_r    <= in_read_channel;
    end
    if (go) begin
      sel_r      <= scan_ch_nxt;
      en_lvl_r   <= !en_low_r;
      upd_r      <= evt.done;
      upd_ch_r   <= evt.done ? evt.channel : '0;
      new_raw_r  <= evt.done ? evt.mean : '0;
      new_filt_r <= evt.done ? new_filt : '0;
      rd_raw_r   <= is_read ? rd_raw : '0;
      rd_filt_r  <= is_read ? rd_filt : '0;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_mux_select       = sel_r;
  assign out_mux_enable_level = en_lvl_r;
  assign out_updated          = upd_r;
  assign out_updated_channel  = upd_ch_r;
  assign out_new_raw          = new_raw_r;
  assign out_new_filtered     = new_filt_r;
  assign out_read_raw         = rd_raw_r;
  assign out_read_filtered    = rd_filt_r;

endmodule
